// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the collision resolver.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dcr_pkg.sv =====
// Shared constants for the disk collision resolver.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dcr_pkg;

  // Default word width of every Q-format field (Q16.16 by default; the
  // fraction point cancels in every ratio, so the datapath never uses it).
  localparam int DCR_WORD_BITS = 32;

  // Register stages inside one dcr_mul instance.
  localparam int DCR_MUL_LAT = 3;

endpackage

`default_nettype wire

// ===== hdl/dcr_pair_if.sv =====
// Input channel of the collision resolver: one disk pair per transfer.
// Depends on dcr_pkg for the default word width.
`timescale 1ns / 1ps
`default_nettype none

interface dcr_pair_if #(
  parameter int WORD_BITS = dcr_pkg::DCR_WORD_BITS
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] pos_a_x;
  logic signed [WORD_BITS-1:0] pos_a_y;
  logic signed [WORD_BITS-1:0] mom_a_x;
  logic signed [WORD_BITS-1:0] mom_a_y;
  logic        [WORD_BITS-2:0] mass_a;
  logic        [WORD_BITS-2:0] radius_a;
  logic signed [WORD_BITS-1:0] pos_b_x;
  logic signed [WORD_BITS-1:0] pos_b_y;
  logic signed [WORD_BITS-1:0] mom_b_x;
  logic signed [WORD_BITS-1:0] mom_b_y;
  logic        [WORD_BITS-2:0] mass_b;
  logic        [WORD_BITS-2:0] radius_b;

  modport source (
    output valid, pos_a_x, pos_a_y, mom_a_x, mom_a_y, mass_a, radius_a,
    output pos_b_x, pos_b_y, mom_b_x, mom_b_y, mass_b, radius_b,
    input  ready
  );
  modport sink (
    input  valid, pos_a_x, pos_a_y, mom_a_x, mom_a_y, mass_a, radius_a,
    input  pos_b_x, pos_b_y, mom_b_x, mom_b_y, mass_b, radius_b,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/dcr_result_if.sv =====
// Output channel of the collision resolver: one resolved pair per transfer.
// Depends on dcr_pkg for the default word width.
`timescale 1ns / 1ps
`default_nettype none

interface dcr_result_if #(
  parameter int WORD_BITS = dcr_pkg::DCR_WORD_BITS
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] new_pos_a_x;
  logic signed [WORD_BITS-1:0] new_pos_a_y;
  logic signed [WORD_BITS-1:0] new_mom_a_x;
  logic signed [WORD_BITS-1:0] new_mom_a_y;
  logic signed [WORD_BITS-1:0] new_pos_b_x;
  logic signed [WORD_BITS-1:0] new_pos_b_y;
  logic signed [WORD_BITS-1:0] new_mom_b_x;
  logic signed [WORD_BITS-1:0] new_mom_b_y;
  logic                        degenerate;

  modport source (
    output valid, new_pos_a_x, new_pos_a_y, new_mom_a_x, new_mom_a_y,
    output new_pos_b_x, new_pos_b_y, new_mom_b_x, new_mom_b_y, degenerate,
    input  ready
  );
  modport sink (
    input  valid, new_pos_a_x, new_pos_a_y, new_mom_a_x, new_mom_a_y,
    input  new_pos_b_x, new_pos_b_y, new_mom_b_x, new_mom_b_y, degenerate,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/dcr_delay.sv =====
// Enable-gated delay line for side data riding along the pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dcr_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];
endmodule

`default_nettype wire

// ===== hdl/dcr_mul.sv =====
// Pipelined signed multiplier: sign-magnitude, two half-width partial
// products, three register stages. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dcr_mul #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] prod
);
  localparam int HA = WA / 2;
  localparam int PW = WA + WB;

  logic [WA-1:0]         mag_a;
  logic [WB-1:0]         mag_b;
  logic                  neg1;
  logic                  neg2;
  logic [HA+WB-1:0]      pp_lo;
  logic [WA-HA+WB-1:0]   pp_hi;
  logic [PW-1:0]         sum;

  assign sum = PW'(pp_lo) + (PW'(pp_hi) << HA);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= a[WA-1] ? WA'(-a) : WA'(a);
      mag_b <= b[WB-1] ? WB'(-b) : WB'(b);
      neg1  <= a[WA-1] ^ b[WB-1];
      pp_lo <= mag_a[HA-1:0] * mag_b;
      pp_hi <= mag_a[WA-1:HA] * mag_b;
      neg2  <= neg1;
      prod  <= neg2 ? $signed(PW'(-sum)) : $signed(sum);
    end
  end
endmodule

`default_nettype wire

// ===== hdl/dcr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; signed numerator,
// unsigned divisor, quotient truncated toward zero. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dcr_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic signed [QW:0]   quo
);
  // Callers guarantee |num| < den * 2^QW, so the top part fits the remainder.
  logic [NW-1:0] nmag;
  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] low  [QW+1];
  logic [QW-1:0] qb   [QW+1];
  logic [DW-1:0] dd   [QW+1];
  logic          neg  [QW+1];

  assign nmag = num[NW-1] ? NW'(-num) : NW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(nmag >> QW);
      low[0] <= nmag[QW-1:0];
      qb[0]  <= '0;
      dd[0]  <= den;
      neg[0] <= num[NW-1];
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[i], low[i][QW-1]};
    assign ge    = trial >= {1'b0, dd[i]};
    assign diff  = trial - {1'b0, dd[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low[i+1] <= low[i] << 1;
        qb[i+1]  <= {qb[i][QW-2:0], ge};
        dd[i+1]  <= dd[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[QW] ? -$signed((QW+1)'(qb[QW])) : $signed((QW+1)'(qb[QW]));
    end
  end
endmodule

`default_nettype wire

// ===== hdl/dcr_sqrt.sv =====
// Pipelined integer square root (floor), one root bit per stage.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dcr_sqrt #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);
  logic [RW:0]     rem [RW];
  logic [RW-1:0]   rt  [RW];
  logic [2*RW-1:0] low [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW:0]     rem_in;
    logic [RW-1:0]   rt_in;
    logic [2*RW-1:0] low_in;
    logic [RW+2:0]   cur;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign rt_in  = '0;
      assign low_in = rad;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign rt_in  = rt[k-1];
      assign low_in = low[k-1];
    end

    assign cur   = {rem_in, low_in[2*RW-1 -: 2]};
    assign trial = (RW+3)'({rt_in, 2'b01});
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[RW:0] : cur[RW:0];
        rt[k]  <= {rt_in[RW-2:0], ge};
        low[k] <= low_in << 2;
      end
    end
  end

  assign root = rt[RW-1];
endmodule

`default_nettype wire

// ===== hdl/disk_collision_resolve.sv =====
// Top level of the elastic 2D disk collision resolver.
// Depends on dcr_pkg, dcr_pair_if, dcr_result_if, dcr_delay, dcr_mul,
// dcr_div, dcr_sqrt and assert_macros.svh.
//
//  channel   dir  transfer carries
//  -------   ---  -----------------------------------------------------
//  pair      in   two disks: position, momentum, mass, radius of A and B
//  result    out  new positions and momenta of A and B, degenerate flag
//
// Throughput is one pair per clock while the result channel is not stalled;
// latency is set by four dependent pipelined divisions.
// Every stage shares one enable: the pipe advances whenever the output
// register is empty or its transfer completes, so a stall freezes all
// stages and nothing is dropped or repeated. Reset clears the valid bits
// only; datapath registers carry no reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module disk_collision_resolve #(
  parameter int WORD_BITS = dcr_pkg::DCR_WORD_BITS
) (
  input  logic         clk,
  input  logic         rst,
  dcr_pair_if.sink     pair,
  dcr_result_if.source result
);
  import dcr_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int ML = DCR_MUL_LAT;

  // Stage boundaries, counted in cycles from the transfer in.
  //  P2: relative-momentum numerators and |d|^2
  //  P3: relative momentum q and L = floor(sqrt(|d|^2))
  //  P4: d.q, push length E
  //  P6: projection d.q / L
  //  P7: reflected impulse P and push vector g
  //  P8: mass-weighted push terms
  localparam int P1  = 1;
  localparam int P2  = P1 + ML + 1;
  localparam int P3  = P2 + W + 2;
  localparam int P4  = P3 + ML + 1;
  localparam int P6  = P4 + W + 3;
  localparam int P7  = P6 + ML + W + 6;
  localparam int P8  = P7 + ML + W + 7;
  localparam int LAT = P8 + 1;

  typedef struct packed {
    logic signed [W-1:0] pax;
    logic signed [W-1:0] pay;
    logic signed [W-1:0] moax;
    logic signed [W-1:0] moay;
    logic signed [W-1:0] pbx;
    logic signed [W-1:0] pby;
    logic signed [W-1:0] mobx;
    logic signed [W-1:0] moby;
    logic [W-2:0]        ma;
    logic [W-2:0]        mb;
    logic [W-1:0]        mt;     // ma + mb
    logic [W-1:0]        rs;     // ra + rb
    logic signed [W:0]   dx;
    logic signed [W:0]   dy;
    logic [W:0]          len;
    logic signed [W+3:0] e;
    logic                deg;
  } side_t;

  typedef struct packed {
    logic [W-2:0] ma;
    logic [W-2:0] mb;
    logic [W-1:0] mt;
  } mass_t;

  // Clamp a wide signed value to the output word.
  function automatic logic signed [W-1:0] sat_word(input logic signed [W+6:0] v);
    logic [7:0] top_bits;
    top_bits = v[W+6:W-1];
    if (&top_bits || ~|top_bits) begin
      return v[W-1:0];
    end
    return v[W+6] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  // ---------------------------------------------------------------- control
  logic           en;
  logic [LAT-1:0] vld;

  assign en         = !result.valid || result.ready;
  assign pair.ready = en;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pair.valid};
    end
  end

  // ---------------------------------------------------------------- P1: capture, d, sums
  side_t side1;

  always_ff @(posedge clk) begin
    if (en) begin
      side1.pax  <= pair.pos_a_x;
      side1.pay  <= pair.pos_a_y;
      side1.moax <= pair.mom_a_x;
      side1.moay <= pair.mom_a_y;
      side1.pbx  <= pair.pos_b_x;
      side1.pby  <= pair.pos_b_y;
      side1.mobx <= pair.mom_b_x;
      side1.moby <= pair.mom_b_y;
      side1.ma   <= pair.mass_a;
      side1.mb   <= pair.mass_b;
      side1.mt   <= {1'b0, pair.mass_a} + {1'b0, pair.mass_b};
      side1.rs   <= {1'b0, pair.radius_a} + {1'b0, pair.radius_b};
      side1.dx   <= (W+1)'(pair.pos_b_x) - (W+1)'(pair.pos_a_x);
      side1.dy   <= (W+1)'(pair.pos_b_y) - (W+1)'(pair.pos_a_y);
      side1.len  <= '0;
      side1.e    <= '0;
      side1.deg  <= 1'b0;
    end
  end

  // mom_a * mb, mom_b * ma and the squares of d
  logic signed [2*W-1:0] p_ax, p_ay, p_bx, p_by;
  logic signed [2*W+1:0] sq_x, sq_y;

  dcr_mul #(.WA(W), .WB(W)) u_mul_ax (.clk, .en, .a(side1.moax),
    .b($signed({1'b0, side1.mb})), .prod(p_ax));
  dcr_mul #(.WA(W), .WB(W)) u_mul_ay (.clk, .en, .a(side1.moay),
    .b($signed({1'b0, side1.mb})), .prod(p_ay));
  dcr_mul #(.WA(W), .WB(W)) u_mul_bx (.clk, .en, .a(side1.mobx),
    .b($signed({1'b0, side1.ma})), .prod(p_bx));
  dcr_mul #(.WA(W), .WB(W)) u_mul_by (.clk, .en, .a(side1.moby),
    .b($signed({1'b0, side1.ma})), .prod(p_by));
  dcr_mul #(.WA(W+1), .WB(W+1)) u_mul_sx (.clk, .en, .a(side1.dx), .b(side1.dx),
    .prod(sq_x));
  dcr_mul #(.WA(W+1), .WB(W+1)) u_mul_sy (.clk, .en, .a(side1.dy), .b(side1.dy),
    .prod(sq_y));

  // ---------------------------------------------------------------- P2
  side_t                 side2_raw, side2;
  logic signed [2*W:0]   qnx, qny;
  logic [2*W+1:0]        l2;

  dcr_delay #(.WIDTH($bits(side_t)), .DEPTH(P2 - P1)) u_dly_12 (
    .clk, .en, .din(side1), .dout(side2_raw));

  always_ff @(posedge clk) begin
    if (en) begin
      qnx <= (2*W+1)'(p_ax) - (2*W+1)'(p_bx);
      qny <= (2*W+1)'(p_ay) - (2*W+1)'(p_by);
      l2  <= $unsigned(sq_x) + $unsigned(sq_y);
    end
  end

  // coincident centers or zero total mass: pass the inputs through
  always_comb begin
    side2     = side2_raw;
    side2.deg = (side2_raw.mt == '0) || (l2 == '0);
  end

  logic signed [W:0] qx, qy;
  logic [W:0]        len_raw, len3;

  dcr_div #(.NW(2*W+1), .DW(W), .QW(W)) u_div_qx (.clk, .en, .num(qnx),
    .den(side2.mt), .quo(qx));
  dcr_div #(.NW(2*W+1), .DW(W), .QW(W)) u_div_qy (.clk, .en, .num(qny),
    .den(side2.mt), .quo(qy));
  dcr_sqrt #(.RW(W+1)) u_sqrt (.clk, .en, .rad(l2), .root(len_raw));
  dcr_delay #(.WIDTH(W+1), .DEPTH(1)) u_dly_len (.clk, .en, .din(len_raw), .dout(len3));

  // ---------------------------------------------------------------- P3
  side_t side3_raw, side3;

  dcr_delay #(.WIDTH($bits(side_t)), .DEPTH(P3 - P2)) u_dly_23 (
    .clk, .en, .din(side2), .dout(side3_raw));

  always_comb begin
    side3     = side3_raw;
    side3.len = len3;
  end

  logic signed [2*W+1:0] dqx, dqy;

  dcr_mul #(.WA(W+1), .WB(W+1)) u_mul_dqx (.clk, .en, .a(side3.dx), .b(qx), .prod(dqx));
  dcr_mul #(.WA(W+1), .WB(W+1)) u_mul_dqy (.clk, .en, .a(side3.dy), .b(qy), .prod(dqy));

  // ---------------------------------------------------------------- P4: d.q and push length
  side_t                 side4_raw, side4;
  logic signed [2*W+2:0] dq;
  logic [W+1:0]          rs_ext, len_ext, gap, span;

  dcr_delay #(.WIDTH($bits(side_t)), .DEPTH(P4 - P3)) u_dly_34 (
    .clk, .en, .din(side3), .dout(side4_raw));

  always_ff @(posedge clk) begin
    if (en) begin
      dq <= (2*W+3)'(dqx) + (2*W+3)'(dqy);
    end
  end

  assign rs_ext  = (W+2)'(side4_raw.rs);
  assign len_ext = (W+2)'(side4_raw.len);
  assign gap     = rs_ext - len_ext;
  assign span    = rs_ext + len_ext;

  // Approaching: twice the overlap, if any. Receding: minus twice S + L.
  always_comb begin
    side4 = side4_raw;
    side4.deg = side4_raw.deg || (dq == '0);
    if (!dq[2*W+2]) begin
      side4.e = (rs_ext > len_ext) ? $signed((W+4)'({gap, 1'b0})) : '0;
    end else begin
      side4.e = -$signed((W+4)'({span, 1'b0}));
    end
  end

  logic signed [W+1:0] proj;

  dcr_div #(.NW(2*W+3), .DW(W+1), .QW(W+1)) u_div_proj (.clk, .en, .num(dq),
    .den(side4_raw.len), .quo(proj));

  // ---------------------------------------------------------------- P6: scale by d
  side_t                 side6;
  logic signed [2*W+2:0] pdx, pdy;
  logic signed [2*W+4:0] edx, edy;
  logic [W:0]            len_m;

  dcr_delay #(.WIDTH($bits(side_t)), .DEPTH(P6 - P4)) u_dly_46 (
    .clk, .en, .din(side4), .dout(side6));
  dcr_delay #(.WIDTH(W+1), .DEPTH(ML)) u_dly_lenm (
    .clk, .en, .din(side6.len), .dout(len_m));

  dcr_mul #(.WA(W+2), .WB(W+1)) u_mul_pdx (.clk, .en, .a(proj), .b(side6.dx), .prod(pdx));
  dcr_mul #(.WA(W+2), .WB(W+1)) u_mul_pdy (.clk, .en, .a(proj), .b(side6.dy), .prod(pdy));
  dcr_mul #(.WA(W+4), .WB(W+1)) u_mul_edx (.clk, .en, .a(side6.e), .b(side6.dx), .prod(edx));
  dcr_mul #(.WA(W+4), .WB(W+1)) u_mul_edy (.clk, .en, .a(side6.e), .b(side6.dy), .prod(edy));

  logic signed [W+2:0] px_raw, py_raw, px8, py8;
  logic signed [W+4:0] gx, gy;

  dcr_div #(.NW(2*W+3), .DW(W+1), .QW(W+2)) u_div_px (.clk, .en, .num(pdx),
    .den(len_m), .quo(px_raw));
  dcr_div #(.NW(2*W+3), .DW(W+1), .QW(W+2)) u_div_py (.clk, .en, .num(pdy),
    .den(len_m), .quo(py_raw));
  dcr_div #(.NW(2*W+5), .DW(W+1), .QW(W+4)) u_div_gx (.clk, .en, .num(edx),
    .den(len_m), .quo(gx));
  dcr_div #(.NW(2*W+5), .DW(W+1), .QW(W+4)) u_div_gy (.clk, .en, .num(edy),
    .den(len_m), .quo(gy));

  // impulse waits for the push path
  dcr_delay #(.WIDTH(W+3), .DEPTH(P8 - P7 + 2)) u_dly_px (
    .clk, .en, .din(px_raw), .dout(px8));
  dcr_delay #(.WIDTH(W+3), .DEPTH(P8 - P7 + 2)) u_dly_py (
    .clk, .en, .din(py_raw), .dout(py8));

  // ---------------------------------------------------------------- P7: weight by mass
  side_t                 side7;
  mass_t                 mass7, mass_m;
  logic signed [2*W+4:0] gxb, gyb, gxa, gya;

  dcr_delay #(.WIDTH($bits(side_t)), .DEPTH(P7 - P6)) u_dly_67 (
    .clk, .en, .din(side6), .dout(side7));

  assign mass7 = '{ma: side7.ma, mb: side7.mb, mt: side7.mt};

  dcr_delay #(.WIDTH($bits(mass_t)), .DEPTH(ML)) u_dly_mass (
    .clk, .en, .din(mass7), .dout(mass_m));

  dcr_mul #(.WA(W+5), .WB(W)) u_mul_gxb (.clk, .en, .a(gx),
    .b($signed({1'b0, side7.mb})), .prod(gxb));
  dcr_mul #(.WA(W+5), .WB(W)) u_mul_gyb (.clk, .en, .a(gy),
    .b($signed({1'b0, side7.mb})), .prod(gyb));
  dcr_mul #(.WA(W+5), .WB(W)) u_mul_gxa (.clk, .en, .a(gx),
    .b($signed({1'b0, side7.ma})), .prod(gxa));
  dcr_mul #(.WA(W+5), .WB(W)) u_mul_gya (.clk, .en, .a(gy),
    .b($signed({1'b0, side7.ma})), .prod(gya));

  logic signed [W+5:0] tax, tay, tbx, tby;

  dcr_div #(.NW(2*W+5), .DW(W), .QW(W+5)) u_div_tax (.clk, .en, .num(gxb),
    .den(mass_m.mt), .quo(tax));
  dcr_div #(.NW(2*W+5), .DW(W), .QW(W+5)) u_div_tay (.clk, .en, .num(gyb),
    .den(mass_m.mt), .quo(tay));
  dcr_div #(.NW(2*W+5), .DW(W), .QW(W+5)) u_div_tbx (.clk, .en, .num(gxa),
    .den(mass_m.mt), .quo(tbx));
  dcr_div #(.NW(2*W+5), .DW(W), .QW(W+5)) u_div_tby (.clk, .en, .num(gya),
    .den(mass_m.mt), .quo(tby));

  // ---------------------------------------------------------------- P8: apply and clamp
  side_t side8;

  dcr_delay #(.WIDTH($bits(side_t)), .DEPTH(P8 - P7)) u_dly_78 (
    .clk, .en, .din(side7), .dout(side8));

  always_ff @(posedge clk) begin
    if (en) begin
      result.degenerate <= side8.deg;
      if (side8.deg) begin
        result.new_pos_a_x <= side8.pax;
        result.new_pos_a_y <= side8.pay;
        result.new_mom_a_x <= side8.moax;
        result.new_mom_a_y <= side8.moay;
        result.new_pos_b_x <= side8.pbx;
        result.new_pos_b_y <= side8.pby;
        result.new_mom_b_x <= side8.mobx;
        result.new_mom_b_y <= side8.moby;
      end else begin
        result.new_pos_a_x <= sat_word((W+7)'(side8.pax) - (W+7)'(tax));
        result.new_pos_a_y <= sat_word((W+7)'(side8.pay) - (W+7)'(tay));
        result.new_pos_b_x <= sat_word((W+7)'(side8.pbx) + (W+7)'(tbx));
        result.new_pos_b_y <= sat_word((W+7)'(side8.pby) + (W+7)'(tby));
        result.new_mom_a_x <= sat_word((W+7)'(side8.moax) - (W+7)'(px8) - (W+7)'(px8));
        result.new_mom_a_y <= sat_word((W+7)'(side8.moay) - (W+7)'(py8) - (W+7)'(py8));
        result.new_mom_b_x <= sat_word((W+7)'(side8.mobx) + (W+7)'(px8) + (W+7)'(px8));
        result.new_mom_b_y <= sat_word((W+7)'(side8.moby) + (W+7)'(py8) + (W+7)'(py8));
      end
    end
  end

  // ---------------------------------------------------------------- checks
  `DCR_ASSERT_NEXT(a_freeze, clk, rst, !en, $stable(vld), "pipe moved while stalled")
  `DCR_ASSERT_NEXT(a_enter, clk, rst, pair.valid && en, vld[0], "transfer in lost at entry")
  `DCR_ASSERT_NEXT(a_bubble, clk, rst, en && !vld[LAT-2], !result.valid, "result from empty stage")
  `DCR_ASSERT_NOW(a_block, clk, rst, result.valid && !result.ready, !pair.ready, "took pair while held")

endmodule

`default_nettype wire
